### src/json_string_escaper_assert.svh
// assertion macros used by the checker file
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

// same-cycle implication, held off during reset
`define JSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("json_string_escaper check failed");

// next-cycle implication, held off during reset
`define JSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("json_string_escaper check failed");

// implication that also holds across reset
`define JSE_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("json_string_escaper check failed");

`endif

### src/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

  // default depth of the queue between classifier and emitter
  localparam int QueueDepth = 4;

  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrU         = 8'h75;
  localparam logic [7:0] ChrQuote     = 8'h22;
  localparam logic [7:0] ChrB         = 8'h62;
  localparam logic [7:0] ChrF         = 8'h66;
  localparam logic [7:0] ChrN         = 8'h6E;
  localparam logic [7:0] ChrR         = 8'h72;
  localparam logic [7:0] ChrT         = 8'h74;

  // what the emitter has to produce for one character
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,  // one byte as is
    KIND_ESC  = 2'd1,  // backslash plus one letter
    KIND_U1   = 2'd2,  // one \uXXXX
    KIND_U2   = 2'd3   // surrogate pair, two \uXXXX
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  chr;  // plain byte or escape letter
    logic [15:0] hi;   // first \u value
    logic [15:0] lo;   // second \u value (pairs only)
  } desc_t;

  // lower-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h57 + {4'd0, n};
    end
    return c;
  endfunction

endpackage

### src/jse_front.sv
`timescale 1ns / 1ps

module jse_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [20:0]         in_code,
  input  logic                in_wide,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  output logic                push,
  output jse_pkg::desc_t      push_desc,
  input  logic                queue_full
);

  logic        utf8_passthrough;
  logic [20:0] v;
  logic [20:0] v_cl;
  logic [19:0] u;
  logic [7:0]  esc;
  logic        need_u;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_passthrough <= 1'b0;
    end else if (cfg_valid) begin
      utf8_passthrough <= cfg_data;
    end
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // narrow characters keep only their low byte
  assign v = in_wide ? in_code : {13'd0, in_code[7:0]};

  // short escapes
  always_comb begin
    case (v)
      21'h22:  esc = jse_pkg::ChrQuote;
      21'h5C:  esc = jse_pkg::ChrBackslash;
      21'h08:  esc = jse_pkg::ChrB;
      21'h0C:  esc = jse_pkg::ChrF;
      21'h0A:  esc = jse_pkg::ChrN;
      21'h0D:  esc = jse_pkg::ChrR;
      21'h09:  esc = jse_pkg::ChrT;
      default: esc = 8'd0;
    endcase
  end

  assign need_u = (v < 21'h20) || ((v >= 21'h80) && (in_wide || !utf8_passthrough));
  // out-of-range code points become the replacement character
  assign v_cl   = (in_wide && (v > 21'h10FFFF)) ? 21'h00FFFD : v;
  assign u      = 20'(v_cl - 21'h10000);

  // descriptor for the emitter
  always_comb begin
    push_desc.kind = jse_pkg::KIND_BYTE;
    push_desc.chr  = v[7:0];
    push_desc.hi   = v_cl[15:0];
    push_desc.lo   = {6'b110111, u[9:0]};
    if (esc != 8'd0) begin
      push_desc.kind = jse_pkg::KIND_ESC;
      push_desc.chr  = esc;
    end else if (need_u) begin
      if (v_cl > 21'h00FFFF) begin
        push_desc.kind = jse_pkg::KIND_U2;
        push_desc.hi   = {6'b110110, u[19:10]};
      end else begin
        push_desc.kind = jse_pkg::KIND_U1;
      end
    end
  end

endmodule

### src/jse_queue.sv
`timescale 1ns / 1ps

module jse_queue #(
  parameter int DEPTH = jse_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  jse_pkg::desc_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output jse_pkg::desc_t rd_data,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jse_pkg::desc_t slots [DEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rp];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wp] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd_en) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/jse_back.sv
`timescale 1ns / 1ps

module jse_back (
  input  logic           clk,
  input  logic           rst,
  input  jse_pkg::desc_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  logic [3:0]  idx;
  logic [3:0]  len_m1;
  logic        load;
  logic        adv;
  logic        last;
  logic        second;
  logic [2:0]  pos;
  logic [15:0] val;
  logic [7:0]  u_byte;
  logic [7:0]  sel;

  // run length minus one of the head descriptor
  always_comb begin
    unique case (head.kind)
      jse_pkg::KIND_BYTE: len_m1 = 4'd0;
      jse_pkg::KIND_ESC:  len_m1 = 4'd1;
      jse_pkg::KIND_U1:   len_m1 = 4'd5;
      jse_pkg::KIND_U2:   len_m1 = 4'd11;
      default:            len_m1 = 4'd0;
    endcase
  end

  assign load = !out_valid || out_ready;
  assign adv  = !empty && load;
  assign last = (idx == len_m1);
  assign pop  = adv && last;

  // position inside the current \uXXXX group
  assign second = (idx >= 4'd6);
  assign pos    = second ? 3'(idx - 4'd6) : idx[2:0];
  assign val    = second ? head.lo : head.hi;

  always_comb begin
    case (pos)
      3'd0:    u_byte = jse_pkg::ChrBackslash;
      3'd1:    u_byte = jse_pkg::ChrU;
      3'd2:    u_byte = jse_pkg::hex_char(val[15:12]);
      3'd3:    u_byte = jse_pkg::hex_char(val[11:8]);
      3'd4:    u_byte = jse_pkg::hex_char(val[7:4]);
      default: u_byte = jse_pkg::hex_char(val[3:0]);
    endcase
  end

  // byte for this step
  always_comb begin
    unique case (head.kind)
      jse_pkg::KIND_BYTE: sel = head.chr;
      jse_pkg::KIND_ESC:  sel = (idx == 4'd0) ? jse_pkg::ChrBackslash : head.chr;
      default:            sel = u_byte;
    endcase
  end

  // output register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (adv) begin
      out_valid <= 1'b1;
      idx       <= last ? 4'd0 : idx + 4'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= sel;
      out_last <= last;
    end
  end

endmodule

### src/json_string_escaper.sv
`timescale 1ns / 1ps
// channel   | direction | payload
// s_axis    | in        | tdata[20:0] char_code, tuser wide_source
// m_axis    | out       | tdata[7:0] out_byte, tlast last_of_run
// cfg       | in        | cfg_data utf8_passthrough
//
// one byte leaves per cycle while m_axis_tready is high; a character becomes 1, 2, 6 or 12 bytes in the
// emitter (plain, short escape, \uXXXX, surrogate pair), set by its step counter
// plain characters stream at one item per cycle while the output is ready, through the queue and output register
// the classifier queue holds DEPTH items, so input stalls only once it fills
// synchronous reset clears the register, queue pointers and output valid
// a stalled output holds its byte while the queue keeps accepting input until it fills

module json_string_escaper #(
  parameter int DEPTH = jse_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] char_code, [23:21] zero
  input  logic        s_axis_tuser,   // [0] wide_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic           push;
  jse_pkg::desc_t push_desc;
  logic           full;
  logic           pop;
  jse_pkg::desc_t head;
  logic           empty;

  // classifier
  jse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_code    (s_axis_tdata[20:0]),
    .in_wide    (s_axis_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_desc  (push_desc),
    .queue_full (full)
  );

  // descriptor queue
  jse_queue #(.DEPTH(DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_desc),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  // byte emitter
  jse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

### src/jse_checker.sv
`timescale 1ns / 1ps
`include "json_string_escaper_assert.svh"

module jse_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  logic out_take;
  logic out_stall;
  logic esc_letter;

  assign out_take   = m_axis_tvalid && m_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  // bytes that may follow a backslash
  assign esc_letter = (m_axis_tdata == jse_pkg::ChrQuote) ||
                      (m_axis_tdata == jse_pkg::ChrBackslash) ||
                      (m_axis_tdata == jse_pkg::ChrB) ||
                      (m_axis_tdata == jse_pkg::ChrF) ||
                      (m_axis_tdata == jse_pkg::ChrN) ||
                      (m_axis_tdata == jse_pkg::ChrR) ||
                      (m_axis_tdata == jse_pkg::ChrT) ||
                      (m_axis_tdata == jse_pkg::ChrU);

  // output is empty right after reset
  `JSE_ASSERT_ALWAYS(a_out_idle_after_reset, $past(rst) && !rst, !m_axis_tvalid)

  // a stalled byte holds
  `JSE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast}))

  // a run never has gaps
  `JSE_ASSERT_NEXT(a_run_no_gap, out_take && !m_axis_tlast, m_axis_tvalid)

  // a backslash inside a run is followed by an escape letter
  `JSE_ASSERT_NEXT(a_esc_letter, out_take && !m_axis_tlast && (m_axis_tdata == jse_pkg::ChrBackslash), esc_letter)

  // configuration is always taken
  `JSE_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind json_string_escaper jse_checker u_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  // character classes
  localparam logic [20:0] CtrlLimit   = 21'h20;
  localparam logic [20:0] HighStart   = 21'h80;
  localparam logic [20:0] BmpMax      = 21'hFFFF;
  localparam logic [20:0] SuppStart   = 21'h10000;
  localparam logic [20:0] UnicodeMax  = 21'h10FFFF;
  localparam logic [20:0] Replacement = 21'hFFFD;
  localparam logic [15:0] HiSurrogate = 16'hD800;
  localparam logic [15:0] LoSurrogate = 16'hDC00;

  // escaped characters
  localparam logic [7:0] CodeQuote     = 8'h22;
  localparam logic [7:0] CodeBackslash = 8'h5C;
  localparam logic [7:0] CodeBs        = 8'h08;
  localparam logic [7:0] CodeFf        = 8'h0C;
  localparam logic [7:0] CodeLf        = 8'h0A;
  localparam logic [7:0] CodeCr        = 8'h0D;
  localparam logic [7:0] CodeTab       = 8'h09;

  localparam int LongHoldCycles = 300;
  localparam int LongHoldAfter  = 150;
  localparam int SettleCycles   = 30;
  localparam int MaxReported    = 10;

  typedef struct {
    logic [20:0] code;
    logic        wide;
  } char_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } json_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [20:0] char_code, [23:21] zero
  logic        s_axis_tuser = 1'b0; // [0] wide_source
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] out_byte
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  char_item_t pending_chars[$];
  json_byte_t json_bytes_q[$];
  logic       passthrough_cfg = 1'b0;
  int         chars_sent = 0;
  int         mismatch_cnt = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         rx_cycle = 0;
  int         hold_left = 0;
  bit         long_hold_done = 1'b0;
  char_item_t next_char;

  json_string_escaper i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ascii hex digit, lower case
  function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'd0, n};
    end
    return 8'h61 + {4'd0, n} - 8'd10;
  endfunction

  function automatic void push_json_byte(input logic [7:0] b);
    json_byte_t jb;
    jb.data = b;
    jb.last = 1'b0;
    json_bytes_q.push_back(jb);
  endfunction

  function automatic void push_u_escape(input logic [15:0] v);
    push_json_byte(jse_pkg::ChrBackslash);
    push_json_byte(jse_pkg::ChrU);
    push_json_byte(nibble_to_ascii(v[15:12]));
    push_json_byte(nibble_to_ascii(v[11:8]));
    push_json_byte(nibble_to_ascii(v[7:4]));
    push_json_byte(nibble_to_ascii(v[3:0]));
  endfunction

  // expected escaped bytes for one accepted character
  function automatic void predict_escape(input char_item_t c);
    logic [20:0] v;
    logic [7:0]  letter;
    logic [19:0] offs;
    v = c.wide ? c.code : {13'd0, c.code[7:0]};
    letter = 8'd0;
    if (v < 21'h100) begin
      case (v[7:0])
        CodeQuote:     letter = jse_pkg::ChrQuote;
        CodeBackslash: letter = jse_pkg::ChrBackslash;
        CodeBs:        letter = jse_pkg::ChrB;
        CodeFf:        letter = jse_pkg::ChrF;
        CodeLf:        letter = jse_pkg::ChrN;
        CodeCr:        letter = jse_pkg::ChrR;
        CodeTab:       letter = jse_pkg::ChrT;
        default:       letter = 8'd0;
      endcase
    end
    if (letter != 8'd0) begin
      push_json_byte(jse_pkg::ChrBackslash);
      push_json_byte(letter);
    end else if (v < CtrlLimit || (v >= HighStart && (c.wide || !passthrough_cfg))) begin
      if (c.wide && v > UnicodeMax) begin
        v = Replacement;
      end
      if (v > BmpMax) begin
        offs = 20'(v - SuppStart);
        push_u_escape(HiSurrogate + {6'd0, offs[19:10]});
        push_u_escape(LoSurrogate + {6'd0, offs[9:0]});
      end else begin
        push_u_escape(v[15:0]);
      end
    end else begin
      push_json_byte(v[7:0]);
    end
    json_bytes_q[json_bytes_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void report_mismatch(input string what, input logic [7:0] exp_data,
                                          input logic exp_last);
    if (mismatch_cnt < MaxReported) begin
      $display("%0t: %s: expected byte %h last %b, got byte %h last %b", $realtime, what,
               exp_data, exp_last, m_axis_tdata, m_axis_tlast);
    end
    mismatch_cnt++;
  endfunction

  function automatic char_item_t mk_char(input logic [20:0] code, input logic wide);
    char_item_t c;
    c.code = code;
    c.wide = wide;
    return c;
  endfunction

  function automatic logic [7:0] random_escaped_code();
    case ($urandom_range(0, 6))
      0: return CodeQuote;
      1: return CodeBackslash;
      2: return CodeBs;
      3: return CodeFf;
      4: return CodeLf;
      5: return CodeCr;
      default: return CodeTab;
    endcase
  endfunction

  // random character, weighted toward the interesting classes
  function automatic char_item_t random_char();
    int pick;
    logic [12:0] junk;
    pick = $urandom_range(0, 99);
    junk = 13'($urandom);
    if (pick < 25) begin
      return mk_char({junk, 8'($urandom_range(8'h20, 8'h7E))}, 1'b0);
    end else if (pick < 45) begin
      return mk_char({junk, 8'($urandom)}, 1'b0);
    end else if (pick < 60) begin
      return mk_char(21'($urandom_range(0, 16'hFFFF)), 1'b1);
    end else if (pick < 75) begin
      return mk_char(21'($urandom_range(SuppStart, UnicodeMax)), 1'b1);
    end else if (pick < 80) begin
      return mk_char(21'($urandom_range(UnicodeMax + 1, 21'h1FFFFF)), 1'b1);
    end else if (pick < 85) begin
      return mk_char(21'($urandom_range(16'hD800, 16'hDFFF)), 1'b1);
    end else if (pick < 92) begin
      return mk_char({junk, random_escaped_code()}, 1'($urandom));
    end
    return mk_char({junk, 8'($urandom_range(0, 8'h1F))}, 1'($urandom));
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_escape(mk_char(s_axis_tdata[20:0], s_axis_tuser));
        chars_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          next_char = pending_chars.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'd0, next_char.code};
          s_axis_tuser  <= next_char.wide;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each byte, stalls on a rotating pattern plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (json_bytes_q.size() == 0) begin
          report_mismatch("byte with nothing pending", 8'd0, 1'b0);
        end else if (m_axis_tdata !== json_bytes_q[0].data ||
                     m_axis_tlast !== json_bytes_q[0].last) begin
          report_mismatch("byte mismatch", json_bytes_q[0].data, json_bytes_q[0].last);
          void'(json_bytes_q.pop_front());
        end else begin
          void'(json_bytes_q.pop_front());
        end
      end
      rx_cycle++;
      if (!long_hold_done && chars_sent >= LongHoldAfter) begin
        long_hold_done = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((rx_cycle >> 6) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= 1'($urandom);
          default: m_axis_tready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  // drain everything, then let the pipeline settle
  task automatic wait_idle();
    while (pending_chars.size() != 0 || s_axis_tvalid || json_bytes_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_passthrough(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    passthrough_cfg = v;
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_chars.push_back(random_char());
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, register still at its reset value
    pending_chars.push_back(mk_char(21'h22, 1'b0));
    pending_chars.push_back(mk_char(21'h5C, 1'b0));
    pending_chars.push_back(mk_char(21'h08, 1'b0));
    pending_chars.push_back(mk_char(21'h0C, 1'b0));
    pending_chars.push_back(mk_char(21'h0A, 1'b0));
    pending_chars.push_back(mk_char(21'h0D, 1'b0));
    pending_chars.push_back(mk_char(21'h09, 1'b0));
    pending_chars.push_back(mk_char(21'h00, 1'b0));
    pending_chars.push_back(mk_char(21'h1F, 1'b0));
    pending_chars.push_back(mk_char(21'h20, 1'b0));
    pending_chars.push_back(mk_char(21'h7F, 1'b0));
    pending_chars.push_back(mk_char(21'h80, 1'b0));
    pending_chars.push_back(mk_char(21'hFF, 1'b0));
    // narrow input ignores bits above the byte
    pending_chars.push_back(mk_char(21'h1FFF41, 1'b0));
    pending_chars.push_back(mk_char(21'h1FFF22, 1'b0));
    pending_chars.push_back(mk_char(21'h5C, 1'b1));
    pending_chars.push_back(mk_char(21'h1F, 1'b1));
    pending_chars.push_back(mk_char(21'h80, 1'b1));
    pending_chars.push_back(mk_char(21'hFFFF, 1'b1));
    // lone surrogates stay a single escape
    pending_chars.push_back(mk_char(21'hD800, 1'b1));
    pending_chars.push_back(mk_char(21'hDFFF, 1'b1));
    // supplementary planes become a pair
    pending_chars.push_back(mk_char(21'h10000, 1'b1));
    pending_chars.push_back(mk_char(21'h10FFFF, 1'b1));
    // past the end of unicode turns into the replacement character
    pending_chars.push_back(mk_char(21'h110000, 1'b1));
    pending_chars.push_back(mk_char(21'h1FFFFF, 1'b1));
    wait_idle();

    // utf-8 pass-through on
    write_passthrough(1'b1);
    pending_chars.push_back(mk_char(21'h80, 1'b0));
    pending_chars.push_back(mk_char(21'h1FFFFF, 1'b0));
    pending_chars.push_back(mk_char(21'hC3, 1'b1));
    queue_random(88);
    wait_idle();

    write_passthrough(1'b0);
    queue_random(88);
    wait_idle();

    write_passthrough(1'b1);
    queue_random(88);
    wait_idle();

    write_passthrough(1'b0);
    queue_random(88);
    wait_idle();

    if (mismatch_cnt == 0 && json_bytes_q.size() == 0) begin
      $display("json_string_escaper test passed");
    end else begin
      $display("json_string_escaper test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("json_string_escaper test failed");
    $finish;
  end

endmodule
